// File: hw/rtl/msep_pkg.sv
// Shared types, constants and helpers of the score event parser.
`timescale 1ns / 1ps
package msep_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [2:0] CMD_NOTE_OFF = 3'd0;
  localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
  localparam logic [2:0] CMD_BEND     = 3'd2;
  localparam logic [2:0] CMD_PATCH    = 3'd3;
  localparam logic [2:0] CMD_VOLUME   = 3'd4;
  localparam logic [2:0] CMD_PAN      = 3'd5;
  localparam logic [2:0] CMD_WAIT     = 3'd6;
  localparam logic [2:0] CMD_END      = 3'd7;

  // result word from the parser; total is zero unless command is wait
  typedef struct packed {
    logic [2:0]      command;
    logic [CH_W-1:0] channel;
    logic [6:0]      first_value;
    logic [6:0]      velocity;
    logic [31:0]     total;
  } res_t;

  // word in flight through the divide-by-seven pipeline
  typedef struct packed {
    logic [2:0]      command;
    logic [CH_W-1:0] channel;
    logic [6:0]      first_value;
    logic [6:0]      velocity;
    logic [35:0]     num;
    logic [2:0]      rem;
  } bk_t;

  typedef struct packed {
    logic [2:0] q;
    logic [2:0] r;
  } d7_t;

  // one radix-8 long-division digit by 7: 8r+d = 7r + (r+d), r+d <= 13
  function automatic d7_t div7_digit(input logic [2:0] r, input logic [2:0] d);
    logic [3:0] s;
    d7_t        o;
    s = {1'b0, r} + {1'b0, d};
    if (s >= 4'd7) begin
      o.q = r + 3'd1;
      o.r = 3'(s - 4'd7);
    end else begin
      o.q = r;
      o.r = s[2:0];
    end
    return o;
  endfunction

endpackage

// File: hw/rtl/msep_front.sv
// Front end: byte parser, velocity store and tick accumulator.
`timescale 1ns / 1ps
module msep_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          accept,
  input  logic [7:0]    score_byte,
  output logic          res_push,
  output msep_pkg::res_t res_word
);
  import msep_pkg::*;

  localparam logic [2:0] PH_EVENT = 3'd0;
  localparam logic [2:0] PH_DATA1 = 3'd1;
  localparam logic [2:0] PH_DATA2 = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_DELAY = 3'd4;

  logic            looping_r;
  logic [2:0]      phase_r, phase_nxt;
  logic [CH_W-1:0] cur_ch_r, cur_ch_nxt;
  logic [2:0]      type_r, type_nxt;
  logic [6:0]      held_r, held_nxt;
  logic            df_r, df_nxt;
  logic [31:0]     delay_r, delay_nxt;
  logic [31:0]     total_r, total_nxt;
  logic            halted_r, halted_nxt;
  logic [6:0]      vel_r [CHANNELS];

  logic            vel_we;
  logic [CH_W-1:0] ev_ch;
  logic [2:0]      ev_type;
  logic            fin;
  logic            fin_df;
  logic            emit;
  res_t            res;

  assign ev_type = score_byte[6:4];

  // channel remap: above 8 moves up one, 15 lands on percussion
  always_comb begin
    if (score_byte[3:0] == 4'd15) begin
      ev_ch = CH_W'(9);
    end else if (score_byte[3:0] > 4'd8) begin
      ev_ch = score_byte[3:0] + 4'd1;
    end else begin
      ev_ch = score_byte[3:0];
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cur_ch_nxt = cur_ch_r;
    type_nxt   = type_r;
    held_nxt   = held_r;
    df_nxt     = df_r;
    delay_nxt  = delay_r;
    total_nxt  = total_r;
    halted_nxt = halted_r;
    vel_we     = 1'b0;
    fin        = 1'b0;
    fin_df     = df_r;
    emit       = 1'b0;
    res        = '0;
    if (!halted_r) begin
      case (phase_r)
        PH_DATA1: begin
          res.channel = cur_ch_r;
          if (type_r == 3'd0) begin
            emit            = 1'b1;
            res.command     = CMD_NOTE_OFF;
            res.first_value = score_byte[6:0];
            res.velocity    = vel_r[cur_ch_r];
            fin             = 1'b1;
          end else if (type_r == 3'd1 && !score_byte[7]) begin
            emit            = 1'b1;
            res.command     = CMD_NOTE_ON;
            res.first_value = score_byte[6:0];
            res.velocity    = vel_r[cur_ch_r];
            fin             = 1'b1;
          end else if (type_r == 3'd2) begin
            emit            = 1'b1;
            res.command     = CMD_BEND;
            res.first_value = score_byte[7:1];
            fin             = 1'b1;
          end else begin
            // note with velocity byte, or controller number
            held_nxt  = score_byte[6:0];
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          res.channel     = cur_ch_r;
          res.first_value = score_byte[6:0];
          fin             = 1'b1;
          if (type_r == 3'd1) begin
            vel_we          = 1'b1;
            emit            = 1'b1;
            res.command     = CMD_NOTE_ON;
            res.first_value = held_r;
            res.velocity    = score_byte[6:0];
          end else if (held_r == 7'd0) begin
            emit        = 1'b1;
            res.command = CMD_PATCH;
          end else if (held_r == 7'd3) begin
            emit        = 1'b1;
            res.command = CMD_VOLUME;
          end else if (held_r == 7'd4) begin
            emit        = 1'b1;
            res.command = CMD_PAN;
          end
        end
        PH_SKIP: begin
          fin = 1'b1;
        end
        PH_DELAY: begin
          delay_nxt = {delay_r[24:0], score_byte[6:0]};
          if (!score_byte[7]) begin
            total_nxt   = total_r + delay_nxt;
            phase_nxt   = PH_EVENT;
            emit        = 1'b1;
            res.command = CMD_WAIT;
            res.total   = total_nxt;
          end
        end
        default: begin
          cur_ch_nxt = ev_ch;
          type_nxt   = ev_type;
          df_nxt     = score_byte[7];
          if (ev_type inside {3'd0, 3'd1, 3'd2, 3'd4}) begin
            phase_nxt = PH_DATA1;
          end else if (ev_type == 3'd3) begin
            phase_nxt = PH_SKIP;
          end else if (ev_type == 3'd6) begin
            emit        = 1'b1;
            res.command = CMD_END;
            phase_nxt   = PH_EVENT;
            if (looping_r) begin
              total_nxt = '0;
              df_nxt    = 1'b0;
            end else begin
              halted_nxt = 1'b1;
            end
          end else begin
            fin    = 1'b1;
            fin_df = score_byte[7];
          end
        end
      endcase
      if (fin) begin
        if (fin_df) begin
          delay_nxt = '0;
          phase_nxt = PH_DELAY;
        end else begin
          phase_nxt = PH_EVENT;
        end
      end
    end
  end

  assign res_push = accept && emit;
  assign res_word = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      looping_r <= 1'b0;
    end else if (cfg_wr_en) begin
      looping_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_EVENT;
      cur_ch_r <= '0;
      type_r   <= '0;
      held_r   <= '0;
      df_r     <= 1'b0;
      delay_r  <= '0;
      total_r  <= '0;
      halted_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        vel_r[i] <= '0;
      end
    end else if (accept) begin
      phase_r  <= phase_nxt;
      cur_ch_r <= cur_ch_nxt;
      type_r   <= type_nxt;
      held_r   <= held_nxt;
      df_r     <= df_nxt;
      delay_r  <= delay_nxt;
      total_r  <= total_nxt;
      halted_r <= halted_nxt;
      if (vel_we) begin
        vel_r[cur_ch_r] <= score_byte[6:0];
      end
    end
  end

endmodule

// File: hw/rtl/msep_queue.sv
// Short queue of result words between parser and back end.
`timescale 1ns / 1ps
module msep_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  msep_pkg::res_t wr_word,
  input  logic           rd_en,
  output msep_pkg::res_t rd_word,
  output logic           q_full,
  output logic           q_empty
);
  import msep_pkg::*;

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_wr, do_rd;

  assign q_full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: hw/rtl/msep_back.sv
// Back end: elastic pipeline computing floor(5*total/7), last stage is the output register.
`timescale 1ns / 1ps
module msep_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  msep_pkg::res_t in_word,
  output logic           in_take,
  input  logic           out_take,
  output logic           out_valid,
  output msep_pkg::bk_t  out_word
);
  import msep_pkg::*;

  localparam int STAGES = 4;

  logic        v_r   [STAGES];
  bk_t         stg_r [STAGES];
  logic        rdy   [STAGES];
  bk_t         nxt   [STAGES];

  always_comb begin
    rdy[STAGES-1] = !v_r[STAGES-1] || out_take;
    for (int j = STAGES - 2; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j+1];
    end
  end

  assign in_take = rdy[0] && in_valid;

  // stage 0 forms 5*total, the rest do four quotient digits each, MSB first
  always_comb begin
    d7_t        dq;
    logic [2:0] rr;
    nxt[0].command     = in_word.command;
    nxt[0].channel     = in_word.channel;
    nxt[0].first_value = in_word.first_value;
    nxt[0].velocity    = in_word.velocity;
    nxt[0].num         = 36'({in_word.total, 2'b00}) + 36'(in_word.total);
    nxt[0].rem         = 3'd0;
    for (int j = 0; j < STAGES - 1; j++) begin
      nxt[j+1] = stg_r[j];
      rr       = stg_r[j].rem;
      for (int i = 0; i < 4; i++) begin
        dq = div7_digit(rr, stg_r[j].num[3*(11-4*j-i) +: 3]);
        nxt[j+1].num[3*(11-4*j-i) +: 3] = dq.q;
        rr = dq.r;
      end
      nxt[j+1].rem = rr;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < STAGES; j++) begin
      if (rdy[j]) begin
        stg_r[j] <= nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < STAGES; j++) begin
        v_r[j] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int j = 1; j < STAGES; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_word  = stg_r[STAGES-1];

endmodule

// File: hw/rtl/mus_score_event_parser.sv
// Top level of the score event parser.
//
// Takes one score byte per cycle (push while full is low) and returns decoded
// events through a queue-style result port (pop while empty is low). Every
// byte is consumed in the cycle it is accepted; a byte that completes an
// event queues at most one result word into a four-word buffer, which
// feeds a four-stage pipeline that computes the wait time floor(5*total/7)
// by radix-8 long division; the last pipeline stage is the output register.
// full rises only when the result side has stalled long enough to fill the
// buffer.
`timescale 1ns / 1ps
module mus_score_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_score_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_command,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_first_value,
  output logic [6:0]  out_velocity,
  output logic [31:0] out_wait_time
);
  import msep_pkg::*;

  logic accept;
  logic res_push;
  res_t res_word;
  res_t q_word;
  logic q_full, q_empty;
  logic q_take;
  logic bk_valid;
  bk_t  bk_word;

  assign accept = push && !q_full;
  assign full   = q_full;

  msep_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .score_byte (in_score_byte),
    .res_push   (res_push),
    .res_word   (res_word)
  );

  msep_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_word(res_word),
    .rd_en  (q_take),
    .rd_word(q_word),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  msep_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (!q_empty),
    .in_word  (q_word),
    .in_take  (q_take),
    .out_take (pop),
    .out_valid(bk_valid),
    .out_word (bk_word)
  );

  assign empty           = !bk_valid;
  assign out_command     = bk_word.command;
  assign out_channel     = bk_word.channel;
  assign out_first_value = bk_word.first_value;
  assign out_velocity    = bk_word.velocity;
  assign out_wait_time   = bk_word.num[31:0];

endmodule

// File: hw/rtl/msep_checker.sv
// Port-level checks of the score event parser, bound to the top level.
`timescale 1ns / 1ps
module msep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_command,
  input logic [3:0]  out_channel,
  input logic [6:0]  out_first_value,
  input logic [6:0]  out_velocity,
  input logic [31:0] out_wait_time
);
  import msep_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("result or input side not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_command) && $stable(out_wait_time)
                          && $stable(out_first_value)))
    else $error("waiting result word changed");

  a_wait_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_command != CMD_WAIT) |-> out_wait_time == 32'd0)
    else $error("wait time set on a non-wait word");

  a_timing_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_command == CMD_WAIT || out_command == CMD_END))
      |-> (out_channel == 4'd0 && out_first_value == 7'd0 && out_velocity == 7'd0))
    else $error("wait or end word carries channel data");

  a_vel_notes: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_command != CMD_NOTE_ON && out_command != CMD_NOTE_OFF)
      |-> out_velocity == 7'd0)
    else $error("velocity set on a non-note word");

endmodule

bind mus_score_event_parser msep_checker u_msep_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_command    (out_command),
  .out_channel    (out_channel),
  .out_first_value(out_first_value),
  .out_velocity   (out_velocity),
  .out_wait_time  (out_wait_time)
);

// File: dv/mus_score_event_parser_tb.sv
// Self-checking testbench for the score event parser: directed and random score streams.
`timescale 1ns / 1ps
module mus_score_event_parser_tb;
  import msep_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_PAD   = 12;
  localparam int HOLD_CYCLES = 400;

  // event types, bits 6..4 of an event byte
  localparam logic [2:0] EV_NOTE_OFF = 3'd0;
  localparam logic [2:0] EV_NOTE_ON  = 3'd1;
  localparam logic [2:0] EV_BEND     = 3'd2;
  localparam logic [2:0] EV_SKIP_ONE = 3'd3;
  localparam logic [2:0] EV_CTRL     = 3'd4;
  localparam logic [2:0] EV_END      = 3'd6;

  localparam logic [6:0] CTRL_PATCH  = 7'd0;
  localparam logic [6:0] CTRL_VOLUME = 7'd3;
  localparam logic [6:0] CTRL_PAN    = 7'd4;

  typedef enum logic [2:0] {
    PH_EVENT, PH_DATA1, PH_DATA2, PH_SKIP, PH_DELAY
  } parse_ph_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  channel;
    logic [6:0]  first_value;
    logic [6:0]  velocity;
    logic [31:0] wait_time;
  } score_evt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_score_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_command;
  logic [3:0]  out_channel;
  logic [6:0]  out_first_value;
  logic [6:0]  out_velocity;
  logic [31:0] out_wait_time;

  mus_score_event_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push            (push),
    .full            (full),
    .in_score_byte   (in_score_byte),
    .empty           (empty),
    .pop             (pop),
    .out_command     (out_command),
    .out_channel     (out_channel),
    .out_first_value (out_first_value),
    .out_velocity    (out_velocity),
    .out_wait_time   (out_wait_time)
  );

  always #2 clk = ~clk;

  // predictor state
  parse_ph_e   parse_ph = PH_EVENT;
  logic [3:0]  cur_ch = '0;
  logic [2:0]  cur_type = '0;
  logic [6:0]  held_num = '0;
  logic        delay_flag = 1'b0;
  logic [6:0]  vel_mem [CHANNELS];
  logic [31:0] delay_acc = '0;
  logic [31:0] tick_total = '0;
  logic        halted_m = 1'b0;
  logic        loop_mode = 1'b0;

  score_evt_t  expected_events [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          cyc = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  initial begin
    for (int i = 0; i < CHANNELS; i++) vel_mem[i] = '0;
  end

  function automatic void queue_event(logic [2:0] cmd, logic [3:0] ch, logic [6:0] v1,
                                      logic [6:0] vel, logic [31:0] wt);
    score_evt_t e;
    e.command = cmd;
    e.channel = ch;
    e.first_value = v1;
    e.velocity = vel;
    e.wait_time = wt;
    expected_events.push_back(e);
  endfunction

  function automatic void finish_evt();
    if (delay_flag) begin
      delay_acc = '0;
      parse_ph = PH_DELAY;
    end else begin
      parse_ph = PH_EVENT;
    end
  endfunction

  // advance the score parser by one accepted word
  function automatic void decode_score_byte(logic [7:0] b);
    logic [3:0]  ch;
    logic [4:0]  rc;
    logic [63:0] prod;
    ch = cur_ch;
    if (halted_m) return;
    case (parse_ph)
      PH_DATA1: begin
        if (cur_type == EV_NOTE_OFF) begin
          queue_event(CMD_NOTE_OFF, ch, b[6:0], vel_mem[ch], '0);
          finish_evt();
        end else if (cur_type == EV_NOTE_ON) begin
          if (b[7]) begin
            held_num = b[6:0];
            parse_ph = PH_DATA2;
          end else begin
            queue_event(CMD_NOTE_ON, ch, b[6:0], vel_mem[ch], '0);
            finish_evt();
          end
        end else if (cur_type == EV_BEND) begin
          queue_event(CMD_BEND, ch, b[7:1], '0, '0);
          finish_evt();
        end else begin
          held_num = b[6:0];
          parse_ph = PH_DATA2;
        end
      end
      PH_DATA2: begin
        finish_evt();
        if (cur_type == EV_NOTE_ON) begin
          vel_mem[ch] = b[6:0];
          queue_event(CMD_NOTE_ON, ch, held_num, b[6:0], '0);
        end else if (held_num == CTRL_PATCH) begin
          queue_event(CMD_PATCH, ch, b[6:0], '0, '0);
        end else if (held_num == CTRL_VOLUME) begin
          queue_event(CMD_VOLUME, ch, b[6:0], '0, '0);
        end else if (held_num == CTRL_PAN) begin
          queue_event(CMD_PAN, ch, b[6:0], '0, '0);
        end
      end
      PH_SKIP: finish_evt();
      PH_DELAY: begin
        delay_acc = {delay_acc[24:0], b[6:0]};
        if (!b[7]) begin
          tick_total = tick_total + delay_acc;
          parse_ph = PH_EVENT;
          prod = {32'd0, tick_total} * 64'd5;
          queue_event(CMD_WAIT, '0, '0, '0, 32'(prod / 64'd7));
        end
      end
      default: begin
        // channel remap: above 8 shifts up one, 15 lands on percussion
        rc = {1'b0, b[3:0]};
        if (rc > 5'd8) rc = rc + 5'd1;
        if (rc == 5'd16) rc = 5'd9;
        cur_ch = rc[3:0];
        cur_type = b[6:4];
        delay_flag = b[7];
        case (cur_type)
          EV_NOTE_OFF, EV_NOTE_ON, EV_BEND, EV_CTRL: parse_ph = PH_DATA1;
          EV_SKIP_ONE: parse_ph = PH_SKIP;
          EV_END: begin
            queue_event(CMD_END, '0, '0, '0, '0);
            parse_ph = PH_EVENT;
            if (loop_mode) begin
              tick_total = '0;
              delay_flag = 1'b0;
            end else begin
              halted_m = 1'b1;
            end
          end
          default: finish_evt();
        endcase
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    push <= 1'b1;
    in_score_byte <= b;
    do @(posedge clk); while (full);
    decode_score_byte(b);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every queued word is out, plus a DRAIN_PAD margin
  task automatic drain_results();
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic set_looping(input bit v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    loop_mode = v;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic sync_to_event();
    while (parse_ph != PH_EVENT && !halted_m) send_byte(8'h00);
  endtask

  task automatic send_random_event(input bit allow_end);
    logic [2:0] ty;
    logic [6:0] ctl;
    bit         flag;
    int         n;
    ty = 3'($urandom_range(0, 7));
    if (ty == EV_END && (!allow_end || $urandom_range(0, 3) != 0)) ty = EV_NOTE_ON;
    flag = 1'($urandom);
    send_byte({flag, ty, 4'($urandom)});
    case (ty)
      EV_NOTE_OFF, EV_BEND, EV_SKIP_ONE: send_byte(8'($urandom));
      EV_NOTE_ON: begin
        if ($urandom_range(0, 1) == 0) begin
          send_byte({1'b1, 7'($urandom)});
          send_byte(8'($urandom));
        end else begin
          send_byte({1'b0, 7'($urandom)});
        end
      end
      EV_CTRL: begin
        case ($urandom_range(0, 3))
          0: ctl = CTRL_PATCH;
          1: ctl = CTRL_VOLUME;
          2: ctl = CTRL_PAN;
          default: ctl = 7'($urandom);
        endcase
        send_byte({1'($urandom), ctl});
        send_byte(8'($urandom));
      end
      default: ;
    endcase
    if (flag && ty != EV_END) begin
      n = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 3);
      for (int i = 1; i < n; i++) send_byte({1'b1, 7'($urandom)});
      send_byte({1'b0, 7'($urandom)});
    end
  endtask

  task automatic test_note_events();
    set_looping(1'b0);
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h1F); send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'h1F); send_byte(8'h05);
    send_byte(8'h09); send_byte(8'h80);
    send_byte(8'h18); send_byte(8'h3C);
  endtask

  task automatic test_controller_events();
    send_byte(8'h2E); send_byte(8'hFF);
    send_byte(8'h40); send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'h48); send_byte(8'h83); send_byte(8'h40);
    send_byte(8'h4E); send_byte(8'h04); send_byte(8'h00);
    send_byte(8'h41); send_byte(8'h7F); send_byte(8'h55);
  endtask

  task automatic test_skip_and_delay();
    send_byte(8'h33); send_byte(8'hAA);
    send_byte(8'h50); send_byte(8'h70);
    send_byte(8'hD0); send_byte(8'h81); send_byte(8'h00);
    // five-word delay overflows both tick counters
    send_byte(8'hF2);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'hB3); send_byte(8'h00); send_byte(8'h01);
  endtask

  task automatic test_end_looping();
    set_looping(1'b1);
    // delay flag on an end must be dropped
    send_byte(8'hE3);
    send_byte(8'h80); send_byte(8'h3C); send_byte(8'h07);
  endtask

  task automatic test_backpressure();
    drain_results();
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_byte({4'h0, 4'($urandom)});
      send_byte(8'($urandom));
    end
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_random_looping();
    int start;
    set_looping(1'b1);
    start = bytes_sent;
    while (bytes_sent - start < 460) begin
      if ($urandom_range(0, 6) == 0) send_byte(8'($urandom));
      else send_random_event(1'b1);
    end
  endtask

  task automatic test_random_play_once();
    int start;
    sync_to_event();
    set_looping(1'b0);
    start = bytes_sent;
    while (bytes_sent - start < 300) send_random_event(1'b0);
  endtask

  task automatic test_end_halts();
    int start;
    drain_results();
    idle_on = 1'b0;
    start = bytes_sent;
    while (bytes_sent - start < 60) send_random_event(1'b0);
    send_byte(8'h6A);
    // halted: everything after is dropped
    repeat (24) send_byte(8'($urandom));
  endtask

  // result side: random stalls, plus one long hold when requested
  initial begin : result_pop
    int hold_cnt;
    int rx_gap;
    hold_cnt = 0;
    rx_gap = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 14);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    score_evt_t want;
    if (rst_n && pop && !empty) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual command %0d", $time,
                 out_command);
      end else begin
        want = expected_events.pop_front();
        check_field("command", 32'(want.command), 32'(out_command));
        check_field("channel", 32'(want.channel), 32'(out_channel));
        check_field("first_value", 32'(want.first_value), 32'(out_first_value));
        check_field("velocity", 32'(want.velocity), 32'(out_velocity));
        check_field("wait_time", want.wait_time, out_wait_time);
      end
    end
  end

  initial begin : watchdog
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("** mus_score_event_parser: FAILED **");
    $finish;
  end

  initial begin : main
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_note_events();
    test_controller_events();
    test_skip_and_delay();
    test_end_looping();
    test_backpressure();
    test_random_looping();
    test_random_play_once();
    test_end_halts();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("** mus_score_event_parser: PASSED **");
    end else begin
      $display("** mus_score_event_parser: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/msep_pkg.sv
hw/rtl/msep_front.sv
hw/rtl/msep_queue.sv
hw/rtl/msep_back.sv
hw/rtl/mus_score_event_parser.sv
hw/rtl/msep_checker.sv
dv/mus_score_event_parser_tb.sv
